/* rtl/gdss_pkg.sv */
// Package for the grid domain split search block.
// Widths, sequencer state type and the shared multiplier request type.
// No dependencies; used by gdss_mul and grid_domain_split_search.
package gdss_pkg;

  localparam int unsigned SizeW = 16;              // size and task count width
  localparam int unsigned CntW  = SizeW + 1;       // loop counters run one past the limit
  localparam int unsigned MulAW = 32;              // multiplier operand a
  localparam int unsigned MulBW = 16;              // multiplier operand b
  localparam int unsigned ProdW = MulAW + MulBW;   // multiplier product
  localparam int unsigned AreaW = 2 * SizeW;       // face area in cells
  localparam int unsigned TermW = 3 * SizeW;       // count times face area
  localparam int unsigned NumW  = 3 * SizeW + 5;   // cost numerator, below 2^53
  localparam int unsigned NumHW = NumW - MulAW;    // upper slice of the numerator
  localparam int unsigned AccW  = NumW + SizeW;    // cross product, below 2^69

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE_XY,
    S_PRE_YZ,
    S_PRE_XZ,
    S_PRE_VOL,
    S_PRE_V10,
    S_I_TOP,
    S_J_TOP,
    S_K_TOP,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MUL4,
    S_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
  } mul_req_t;

endpackage

/* rtl/grid_domain_split_search.sv */
// Top level of the grid domain split search block.
// Depends on gdss_pkg and gdss_mul (the shared multiplier).
//
// A request (three grid sizes, a task count) is a transfer at a rising edge with start_i
// high and busy_o low. The block then walks all splits (i,j,k) with each count at most
// min(tasks, size) and i*j*k at most tasks, i-major, and keeps the split of least cost
// (ten volumes plus count times face area per split axis), first minimum winning ties.
// Costs are compared exactly as cross products of numerator and task product.
// When done, valid_o is high for exactly one cycle with the split and the failed flag;
// the receiver takes it in that cycle and cannot stall it. failed_o is set when the
// split product differs from the task count, or when a size or the task count is zero
// (split 1,1,1 is then returned at once).
// Order, from the transfer to the strobe: the setup states S_PRE_XY to S_PRE_V10 form
// the face areas and the ten volumes, then the i, j and k loops walk the splits. The
// first candidate is kept without compare; each later candidate goes through S_MUL0 to
// S_MUL4 and S_CMP, where the four 32x16 products of its cross compare run on the single
// shared multiplier. The strobe comes from S_DONE.
// busy_o stays high for the whole search.
module grid_domain_split_search import gdss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [SizeW-1:0] size_x_i,
  input  logic [SizeW-1:0] size_y_i,
  input  logic [SizeW-1:0] size_z_i,
  input  logic [SizeW-1:0] task_count_i,
  output logic             valid_o,
  output logic [SizeW-1:0] split_x_o,
  output logic [SizeW-1:0] split_y_o,
  output logic [SizeW-1:0] split_z_o,
  output logic             failed_o
);

  // control state
  state_e state_q, state_d;
  logic   found_q, found_d;

  // request and limits
  logic [SizeW-1:0] sx_q, sx_d, sy_q, sy_d, sz_q, sz_d, t_q, t_d;
  logic [SizeW-1:0] lim_i_q, lim_i_d, lim_j_q, lim_j_d, lim_k_q, lim_k_d;

  // precomputed face areas and ten volumes
  logic [AreaW-1:0] sxy_q, sxy_d, syz_q, syz_d, sxz_q, sxz_d;
  logic [NumW-1:0]  vol10_q, vol10_d;

  // loop counters and running terms (count times face area)
  logic [CntW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d, ij_q, ij_d, p_q, p_d;
  logic [TermW-1:0] ti_q, ti_d, tj_q, tj_d, tk_q, tk_d;
  logic [NumW-1:0]  base_q, base_d, n_q, n_d;
  logic [AccW-1:0]  acc_a_q, acc_a_d, acc_b_q, acc_b_d;

  // kept split
  logic [SizeW-1:0] best_i_q, best_i_d, best_j_q, best_j_d, best_k_q, best_k_d;
  logic [SizeW-1:0] best_p_q, best_p_d;
  logic [NumW-1:0]  best_n_q, best_n_d;

  mul_req_t         mul_req;
  logic [ProdW-1:0] prod;

  logic [NumW-1:0]  n_cand;
  logic             take;

  gdss_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // numerator of the current candidate: base of the (i,j) pair plus the k face term
  assign n_cand = base_q + ((k_q > CntW'(1)) ? NumW'(tk_q) : NumW'(0));

  always_comb begin
    state_d  = state_q;
    found_d  = found_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    sz_d     = sz_q;
    t_d      = t_q;
    lim_i_d  = lim_i_q;
    lim_j_d  = lim_j_q;
    lim_k_d  = lim_k_q;
    sxy_d    = sxy_q;
    syz_d    = syz_q;
    sxz_d    = sxz_q;
    vol10_d  = vol10_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    ij_d     = ij_q;
    p_d      = p_q;
    ti_d     = ti_q;
    tj_d     = tj_q;
    tk_d     = tk_q;
    base_d   = base_q;
    n_d      = n_q;
    acc_a_d  = acc_a_q;
    acc_b_d  = acc_b_q;
    best_i_d = best_i_q;
    best_j_d = best_j_q;
    best_k_d = best_k_q;
    best_p_d = best_p_q;
    best_n_d = best_n_q;
    mul_req  = '0;
    take     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          sx_d     = size_x_i;
          sy_d     = size_y_i;
          sz_d     = size_z_i;
          t_d      = task_count_i;
          lim_i_d  = (task_count_i < size_x_i) ? task_count_i : size_x_i;
          lim_j_d  = (task_count_i < size_y_i) ? task_count_i : size_y_i;
          lim_k_d  = (task_count_i < size_z_i) ? task_count_i : size_z_i;
          found_d  = 1'b0;
          best_i_d = SizeW'(1);
          best_j_d = SizeW'(1);
          best_k_d = SizeW'(1);
          best_p_d = SizeW'(1);
          // any zero input: nothing to search
          if (size_x_i == '0 || size_y_i == '0 || size_z_i == '0 ||
              task_count_i == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PRE_XY;
          end
        end
      end
      S_PRE_XY: begin
        mul_req.a = MulAW'(sx_q);
        mul_req.b = sy_q;
        state_d   = S_PRE_YZ;
      end
      S_PRE_YZ: begin
        mul_req.a = MulAW'(sy_q);
        mul_req.b = sz_q;
        sxy_d     = prod[AreaW-1:0];
        state_d   = S_PRE_XZ;
      end
      S_PRE_XZ: begin
        mul_req.a = MulAW'(sx_q);
        mul_req.b = sz_q;
        syz_d     = prod[AreaW-1:0];
        state_d   = S_PRE_VOL;
      end
      S_PRE_VOL: begin
        mul_req.a = sxy_q;
        mul_req.b = sz_q;
        sxz_d     = prod[AreaW-1:0];
        state_d   = S_PRE_V10;
      end
      S_PRE_V10: begin
        // ten volumes as 8v + 2v
        vol10_d = NumW'({prod, 3'b000}) + NumW'({prod, 1'b0});
        i_d     = CntW'(1);
        ti_d    = TermW'(syz_q);
        state_d = S_I_TOP;
      end
      S_I_TOP: begin
        if (i_q > CntW'(lim_i_q)) begin
          state_d = S_DONE;
        end else begin
          j_d     = CntW'(1);
          ij_d    = i_q;
          tj_d    = TermW'(sxz_q);
          state_d = S_J_TOP;
        end
      end
      S_J_TOP: begin
        if (j_q > CntW'(lim_j_q) || ij_q > CntW'(t_q)) begin
          i_d     = i_q + CntW'(1);
          ti_d    = ti_q + TermW'(syz_q);
          state_d = S_I_TOP;
        end else begin
          k_d     = CntW'(1);
          p_d     = ij_q;
          tk_d    = TermW'(sxy_q);
          base_d  = vol10_q
                  + ((i_q > CntW'(1)) ? NumW'(ti_q) : NumW'(0))
                  + ((j_q > CntW'(1)) ? NumW'(tj_q) : NumW'(0));
          state_d = S_K_TOP;
        end
      end
      S_K_TOP: begin
        if (k_q > CntW'(lim_k_q) || p_q > CntW'(t_q)) begin
          j_d     = j_q + CntW'(1);
          ij_d    = ij_q + i_q;
          tj_d    = tj_q + TermW'(sxz_q);
          state_d = S_J_TOP;
        end else if (!found_q) begin
          // first candidate is kept without compare
          n_d  = n_cand;
          take = 1'b1;
        end else begin
          n_d     = n_cand;
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        mul_req.a = n_q[MulAW-1:0];
        mul_req.b = best_p_q;
        state_d   = S_MUL1;
      end
      S_MUL1: begin
        mul_req.a = MulAW'(n_q[NumW-1:MulAW]);
        mul_req.b = best_p_q;
        acc_a_d   = AccW'(prod);
        state_d   = S_MUL2;
      end
      S_MUL2: begin
        mul_req.a = best_n_q[MulAW-1:0];
        mul_req.b = p_q[SizeW-1:0];
        acc_a_d   = acc_a_q + {prod[AccW-MulAW-1:0], {MulAW{1'b0}}};
        state_d   = S_MUL3;
      end
      S_MUL3: begin
        mul_req.a = MulAW'(best_n_q[NumW-1:MulAW]);
        mul_req.b = p_q[SizeW-1:0];
        acc_b_d   = AccW'(prod);
        state_d   = S_MUL4;
      end
      S_MUL4: begin
        acc_b_d = acc_b_q + {prod[AccW-MulAW-1:0], {MulAW{1'b0}}};
        state_d = S_CMP;
      end
      S_CMP: begin
        // strictly smaller cost only: first minimum wins ties
        take    = 1'b1;
        if (!(acc_a_q < acc_b_q)) take = 1'b0;
        state_d = S_K_TOP;
        if (!take) begin
          k_d  = k_q + CntW'(1);
          p_d  = p_q + ij_q;
          tk_d = tk_q + TermW'(sxy_q);
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // keep the candidate and step k
    if (take) begin
      found_d  = 1'b1;
      best_i_d = i_q[SizeW-1:0];
      best_j_d = j_q[SizeW-1:0];
      best_k_d = k_q[SizeW-1:0];
      best_p_d = p_q[SizeW-1:0];
      best_n_d = n_d;
      k_d      = k_q + CntW'(1);
      p_d      = p_q + ij_q;
      tk_d     = tk_q + TermW'(sxy_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    sz_q     <= sz_d;
    t_q      <= t_d;
    lim_i_q  <= lim_i_d;
    lim_j_q  <= lim_j_d;
    lim_k_q  <= lim_k_d;
    sxy_q    <= sxy_d;
    syz_q    <= syz_d;
    sxz_q    <= sxz_d;
    vol10_q  <= vol10_d;
    i_q      <= i_d;
    j_q      <= j_d;
    k_q      <= k_d;
    ij_q     <= ij_d;
    p_q      <= p_d;
    ti_q     <= ti_d;
    tj_q     <= tj_d;
    tk_q     <= tk_d;
    base_q   <= base_d;
    n_q      <= n_d;
    acc_a_q  <= acc_a_d;
    acc_b_q  <= acc_b_d;
    best_i_q <= best_i_d;
    best_j_q <= best_j_d;
    best_k_q <= best_k_d;
    best_p_q <= best_p_d;
    best_n_q <= best_n_d;
  end

  assign busy_o    = (state_q != S_IDLE);
  assign valid_o   = (state_q == S_DONE);
  assign split_x_o = best_i_q;
  assign split_y_o = best_j_q;
  assign split_z_o = best_k_q;
  assign failed_o  = !found_q || (best_p_q != t_q);

endmodule

/* rtl/gdss_mul.sv */
// Shared 32x16 unsigned multiplier with a registered product.
// Depends on gdss_pkg (widths, mul_req_t).
module gdss_mul import gdss_pkg::*; (
  input  logic             clk_i,
  input  mul_req_t         req_i,
  output logic [ProdW-1:0] prod_o
);

  logic [ProdW-1:0] prod_q;

  // Registered: the product of this cycle's request shows in the next cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(req_i.a) * ProdW'(req_i.b);
  end

  assign prod_o = prod_q;

endmodule
